[hw/rtl/sha1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared constants and the request type passed from front end to core.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // one queued request: a byte and/or an end mark
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_req;

endpackage

[hw/rtl/sha1_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 front queue
// Accepts input requests into a small FIFO that decouples the core.
// ----------------------------------------------------------------------------
module sha1_front
    import sha1_pkg::*;
#(
    parameter int DEPTH_LOG2 = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_req i_req,
    output logic o_req_valid,
    output t_req o_req,
    input  logic i_req_take
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_req                r_mem [DEPTH];
    logic [DEPTH_LOG2:0] r_wr, n_wr, r_rd, n_rd;
    logic                w_push, w_pop;

    assign o_full      = (r_wr - r_rd) == DEPTH_LOG2'(0) + (DEPTH_LOG2+1)'(DEPTH);
    assign o_req_valid = r_wr != r_rd;
    assign o_req       = r_mem[r_rd[DEPTH_LOG2-1:0]];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_req_take && o_req_valid;
    assign n_wr        = r_wr + (DEPTH_LOG2+1)'(w_push);
    assign n_rd        = r_rd + (DEPTH_LOG2+1)'(w_pop);

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    // store request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr[DEPTH_LOG2-1:0]] <= i_req;
        end
    end

    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) <= (DEPTH_LOG2+1)'(DEPTH)) else $error("fifo overflow");
    a_nopop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_req_valid |=> r_rd == $past(r_rd)) else $error("pop from empty");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !w_pop) |=> r_wr == $past(r_wr)) else $error("push while full");
endmodule

[hw/rtl/sha1_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 core
// Loads bytes, pads, runs 80 rounds per block and emits the digest words.
// ----------------------------------------------------------------------------
module sha1_core
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  t_req        i_req,
    output logic        o_req_take,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);
    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_st;
    logic [31:0] r_blk [16];    // block words, later the schedule window
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_t;
    logic        r_fin;          // padding pending after this block
    logic        r_two;          // second pad block still needed
    logic        r_lenb;         // current block carries the length
    logic [2:0]  r_oi;

    logic [31:0] w_w, w_f, w_k, w_tmp;
    logic [3:0]  w_slot;

    assign w_slot = r_t[3:0];

    // message schedule word
    always_comb begin
        if (r_t < 7'd16) begin
            w_w = r_blk[w_slot];
        end else begin
            w_w = r_blk[w_slot - 4'd3] ^ r_blk[w_slot - 4'd8] ^
                  r_blk[w_slot - 4'd14] ^ r_blk[w_slot];
            w_w = {w_w[30:0], w_w[31]};
        end
    end

    // round function select
    always_comb begin
        priority if (r_t < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K0;
        end else if (r_t < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_t < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
    end

    assign w_tmp = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_w;

    assign o_req_take    = (r_st == ST_LOAD) && i_req_valid;
    assign o_empty       = r_st != ST_OUT;
    assign o_digest_word = r_h[r_oi];
    assign o_digest_last = r_oi == 3'd4;

    // control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_LOAD;
            r_fill <= '0;
            r_len  <= '0;
            r_fin  <= 1'b0;
            r_two  <= 1'b0;
            r_lenb <= 1'b0;
            r_oi   <= '0;
            r_t    <= '0;
            r_h    <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
        end else begin
            unique case (r_st)
                ST_LOAD: begin
                    if (i_req_valid) begin
                        if (i_req.byte_present) begin
                            r_fill <= r_fill + 6'd1;
                            r_len  <= r_len + 64'd8;
                        end
                        r_fin <= i_req.end_of_message;
                        if (i_req.byte_present && r_fill == 6'd63) begin
                            r_st   <= ST_RND;
                            r_t    <= '0;
                            r_lenb <= 1'b0;
                            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                            r_d <= r_h[3]; r_e <= r_h[4];
                        end else if (i_req.end_of_message) begin
                            r_st <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    // one block with marker; length fits only if fill <= 55
                    r_fin  <= 1'b0;
                    r_two  <= r_fill > 6'd55;
                    r_lenb <= r_fill <= 6'd55;
                    r_st   <= ST_RND;
                    r_t    <= '0;
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                end
                ST_RND: begin
                    r_e <= r_d;
                    r_d <= r_c;
                    r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a;
                    r_a <= w_tmp;
                    r_t <= r_t + 7'd1;
                    if (r_t == 7'd79) begin
                        r_st <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_fill <= '0;
                    priority if (r_fin) begin
                        r_st <= ST_PAD;
                    end else if (r_two) begin
                        r_two  <= 1'b0;
                        r_lenb <= 1'b1;
                        r_st   <= ST_RND;
                        r_t    <= '0;
                        r_a <= r_h[0] + r_a; r_b <= r_h[1] + r_b;
                        r_c <= r_h[2] + r_c; r_d <= r_h[3] + r_d;
                        r_e <= r_h[4] + r_e;
                    end else if (r_lenb) begin
                        r_st <= ST_OUT;
                        r_oi <= '0;
                    end else begin
                        r_st <= ST_LOAD;
                    end
                end
                ST_OUT: begin
                    if (i_pop) begin
                        if (r_oi == 3'd4) begin
                            r_oi   <= '0;
                            r_st   <= ST_LOAD;
                            r_len  <= '0;
                            r_lenb <= 1'b0;
                            r_h    <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
                        end else begin
                            r_oi <= r_oi + 3'd1;
                        end
                    end
                end
                default: r_st <= ST_LOAD;
            endcase
        end
    end

    // block words: byte load, padding, schedule update, second pad block
    always_ff @(posedge i_clk) begin
        if (r_st == ST_LOAD && i_req_valid && i_req.byte_present) begin
            unique case (r_fill[1:0])
                2'd0: r_blk[r_fill[5:2]][31:24] <= i_req.msg_byte;
                2'd1: r_blk[r_fill[5:2]][23:16] <= i_req.msg_byte;
                2'd2: r_blk[r_fill[5:2]][15:8]  <= i_req.msg_byte;
                default: r_blk[r_fill[5:2]][7:0] <= i_req.msg_byte;
            endcase
        end else if (r_st == ST_PAD) begin
            // marker at the fill point, then zeros, length in the last 8 bytes if it fits
            for (int i = 0; i < 16; i++) begin
                for (int j = 0; j < 4; j++) begin
                    if (6'(i * 4 + j) == r_fill) begin
                        r_blk[i][31-8*j -: 8] <= PAD_MARK;
                    end else if (i >= 14 && r_fill <= 6'd55) begin
                        r_blk[i][31-8*j -: 8] <= r_len[63-8*((i-14)*4+j) -: 8];
                    end else if (6'(i * 4 + j) > r_fill) begin
                        r_blk[i][31-8*j -: 8] <= 8'h00;
                    end
                end
            end
        end else if (r_st == ST_RND) begin
            r_blk[w_slot] <= w_w;
        end else if (r_st == ST_FOLD && r_two) begin
            for (int i = 0; i < 14; i++) begin
                r_blk[i] <= '0;
            end
            r_blk[14] <= r_len[63:32];
            r_blk[15] <= r_len[31:0];
        end
    end

    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> r_oi <= 3'd4) else $error("digest index out of range");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_take |-> r_st == ST_LOAD) else $error("take outside load");
    a_rnd_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_RND && r_t == 7'd79) |=> r_st == ST_FOLD) else $error("round count");
endmodule

[hw/rtl/sha1_message_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message hasher
// Byte-serial SHA-1 digest engine with queue-style channels.
// ----------------------------------------------------------------------------
// Input channel: raise push with msg_byte / byte_present / end_of_message;
// a request is taken on a clock edge where push is high and full is low.
// A four-entry queue holds requests while the core is busy compressing.
// Output channel: empty low shows the next digest word (H0 first);
// pop takes it. o_digest_last marks the fifth word.
// A byte is written straight into the block words; each full block runs 80
// rounds in one shared round unit, then a fold. An end request adds a
// padding step and one or two blocks, then the five words appear.
// The core takes no bytes while compressing; the round unit limits the rate.
// Reset (i_rst_n low, synchronous) empties the queue and loads the initial
// hash. While the receiver does not pop, the core holds the digest and
// stops taking requests; the queue keeps filling until full.
// ----------------------------------------------------------------------------
module sha1_message_hasher
    import sha1_pkg::*;
#(
    parameter int QUEUE_LOG2 = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);
    t_req w_in, w_req;
    logic w_valid, w_take;

    assign w_in = '{msg_byte: i_msg_byte, byte_present: i_byte_present,
                    end_of_message: i_end_of_message};

    sha1_front #(.DEPTH_LOG2(QUEUE_LOG2)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_req(w_in),
        .o_req_valid(w_valid), .o_req(w_req), .i_req_take(w_take));

    sha1_core u_core (
        .i_clk, .i_rst_n, .i_req_valid(w_valid), .i_req(w_req),
        .o_req_take(w_take), .o_empty(empty), .i_pop(pop),
        .o_digest_word, .o_digest_last);
endmodule
